[design/lobm_pkg.sv]
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

    localparam int PRICE_W = 8;
    localparam int QTY_W   = 32;
    localparam int ID_W    = 32;

    typedef enum logic [2:0] {
        KIND_TRADE   = 3'd0,
        KIND_NO_FILL = 3'd1,
        KIND_RESTED  = 3'd2,
        KIND_REJECT  = 3'd3,
        KIND_CAPPED  = 3'd4
    } kind_t;

    // A classified command as it travels from the front to the back.
    typedef struct packed {
        logic               is_match;
        logic               side;
        logic               range_bad;
        logic [PRICE_W-1:0] limit;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    id;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    buyer;
        logic [ID_W-1:0]    seller;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [QTY_W-1:0]   rem;
        logic               last;
    } res_t;

endpackage

[design/lobm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lobm_ram import lobm_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/lobm_front.sv]
// Front end: accepts commands, classifies them and queues them for the back end.
module lobm_front import lobm_pkg::*; #(
    parameter int PRICE_TICKS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic               side,
    input  logic [PRICE_W-1:0] limit_price,
    input  logic [QTY_W-1:0]   order_quantity,
    input  logic [ID_W-1:0]    order_id,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_take
);

    cmd_t       q_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       do_push;

    // An add beyond the configured price range is rejected without a book access.
    always_comb
    begin
        cls.is_match  = command;
        cls.side      = side;
        cls.range_bad = !command && (32'(limit_price) >= 32'(PRICE_TICKS));
        cls.limit     = limit_price;
        cls.qty       = order_quantity;
        cls.id        = order_id;
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg ^ do_push;
        rd_next  = rd_reg ^ cmd_take;
        cnt_next = cnt_reg + 2'(do_push) - 2'(cmd_take);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/lobm_back.sv]
// Back end: walks the books, applies fills and queues the results.
module lobm_back import lobm_pkg::*; #(
    parameter int PRICE_TICKS = 256,
    parameter int LEVEL_DEPTH = 16,
    parameter int MAX_FILLS   = 63
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic empty,
    output res_t res,
    input  logic pop
);

    localparam int NLEV    = (PRICE_TICKS < 256) ? PRICE_TICKS : 256;
    localparam int PB      = $clog2(NLEV);
    localparam int LW      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW      = $clog2(LEVEL_DEPTH + 1);
    localparam int LVL_N   = 2 << PB;
    localparam int LVL_A   = PB + 1;
    localparam int ST_N    = LVL_N << LW;
    localparam int ST_A    = LVL_A + LW;
    localparam logic [PRICE_W-1:0] TOP = PRICE_W'(NLEV - 1);
    localparam logic [5:0] CAP = 6'(MAX_FILLS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ADD   = 7'b0000100,
        S_LVL   = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               c_reg, c_next;
    logic [PRICE_W-1:0] p_reg, p_next;
    logic [QTY_W-1:0]   rem_reg, rem_next;
    logic [5:0]         n_reg, n_next;
    logic               cap_reg, cap_next;
    logic [LW-1:0]      head_reg, head_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [LVL_A-1:0]   la_reg, la_next;
    logic [ST_A-1:0]    sa_reg, sa_next;
    logic [LVL_A-1:0]   clr_reg, clr_next;

    logic               lvl_we;
    logic [LVL_A-1:0]   lvl_waddr;
    logic [LW+CW-1:0]   lvl_wdata, lvl_rdata;
    logic               st_we;
    logic [ST_A-1:0]    st_waddr;
    logic [63:0]        st_wdata, st_rdata;

    logic               emit;
    res_t               res_in;
    res_t               oq_reg [2];
    logic               ow_reg, or_reg;
    logic [1:0]         oc_reg;
    logic               room;

    logic [LW-1:0]      r_head;
    logic [CW-1:0]      r_cnt;
    logic [LW-1:0]      slot;
    logic [LW-1:0]      head_inc;
    logic [QTY_W-1:0]   top_q, fill_q, top_left;
    logic [ID_W-1:0]    own_buy, own_sell;

    lobm_ram #(.WIDTH(LW + CW), .DEPTH(LVL_N)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (la_next),
        .rdata (lvl_rdata)
    );

    lobm_ram #(.WIDTH(64), .DEPTH(ST_N)) u_order_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (sa_next),
        .rdata (st_rdata)
    );

    assign r_head   = lvl_rdata[LW+CW-1:CW];
    assign r_cnt    = lvl_rdata[CW-1:0];
    assign slot     = LW'((32'(r_head) + 32'(r_cnt)) >= 32'(LEVEL_DEPTH) ?
                          32'(r_head) + 32'(r_cnt) - 32'(LEVEL_DEPTH) :
                          32'(r_head) + 32'(r_cnt));
    assign head_inc = LW'((32'(head_reg) + 32'd1) >= 32'(LEVEL_DEPTH) ?
                          32'd0 : 32'(head_reg) + 32'd1);
    assign top_q    = st_rdata[QTY_W-1:0];
    assign fill_q   = (rem_reg < top_q) ? rem_reg : top_q;
    assign top_left = top_q - fill_q;
    assign own_buy  = c_reg.side ? '0 : c_reg.id;
    assign own_sell = c_reg.side ? c_reg.id : '0;
    assign room     = (oc_reg != 2'd2);

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        cap_next   = cap_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        la_next    = la_reg;
        sa_next    = sa_reg;
        clr_next   = clr_reg;
        cmd_take   = 1'b0;
        lvl_we     = 1'b0;
        lvl_waddr  = la_reg;
        lvl_wdata  = '0;
        st_we      = 1'b0;
        st_waddr   = sa_reg;
        st_wdata   = {c_reg.id, c_reg.qty};
        emit       = 1'b0;
        res_in.kind   = KIND_NO_FILL;
        res_in.buyer  = own_buy;
        res_in.seller = own_sell;
        res_in.price  = c_reg.limit;
        res_in.qty    = '0;
        res_in.rem    = rem_reg;
        res_in.last   = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                lvl_we    = 1'b1;
                lvl_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LVL_A'(LVL_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_match && cmd.range_bad)
                    begin
                        if (room)
                        begin
                            cmd_take      = 1'b1;
                            emit          = 1'b1;
                            res_in.kind   = KIND_REJECT;
                            res_in.buyer  = cmd.side ? '0 : cmd.id;
                            res_in.seller = cmd.side ? cmd.id : '0;
                            res_in.price  = cmd.limit;
                            res_in.rem    = cmd.qty;
                        end
                    end
                    else if (!cmd.is_match)
                    begin
                        cmd_take   = 1'b1;
                        c_next     = cmd;
                        la_next    = {cmd.side, cmd.limit[PB-1:0]};
                        state_next = S_ADD;
                    end
                    else
                    begin
                        cmd_take = 1'b1;
                        c_next   = cmd;
                        rem_next = cmd.qty;
                        n_next   = '0;
                        cap_next = 1'b0;
                        if (cmd.qty == '0 || (cmd.side && cmd.limit > TOP))
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            p_next     = cmd.side ? TOP : '0;
                            la_next    = {!cmd.side, p_next[PB-1:0]};
                            state_next = S_LVL;
                        end
                    end
                end
            end
            S_ADD:
            begin
                if (room)
                begin
                    emit       = 1'b1;
                    res_in.rem = c_reg.qty;
                    state_next = S_IDLE;
                    if (32'(r_cnt) >= 32'(LEVEL_DEPTH))
                    begin
                        res_in.kind = KIND_REJECT;
                    end
                    else
                    begin
                        res_in.kind = KIND_RESTED;
                        st_waddr    = {la_reg, slot};
                        lvl_we      = 1'b1;
                        lvl_wdata   = {r_head, r_cnt + 1'b1};
                        st_we       = 1'b1;
                    end
                end
            end
            S_LVL:
            begin
                head_next  = r_head;
                cnt_next   = r_cnt;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cnt_reg == '0)
                begin
                    if (!c_reg.side && p_reg < TOP && p_reg < c_reg.limit)
                    begin
                        p_next     = p_reg + 1'b1;
                        la_next    = {1'b1, p_next[PB-1:0]};
                        state_next = S_LVL;
                    end
                    else if (c_reg.side && p_reg > c_reg.limit)
                    begin
                        p_next     = p_reg - 1'b1;
                        la_next    = {1'b0, p_next[PB-1:0]};
                        state_next = S_LVL;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (n_reg == CAP)
                begin
                    cap_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    sa_next    = {la_reg, head_reg};
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (room)
                begin
                    emit          = 1'b1;
                    res_in.kind   = KIND_TRADE;
                    res_in.buyer  = c_reg.side ? st_rdata[63:32] : c_reg.id;
                    res_in.seller = c_reg.side ? c_reg.id : st_rdata[63:32];
                    res_in.price  = p_reg;
                    res_in.qty    = fill_q;
                    res_in.rem    = rem_reg - fill_q;
                    res_in.last   = 1'b0;
                    rem_next      = rem_reg - fill_q;
                    n_next        = n_reg + 1'b1;
                    if (top_left == '0)
                    begin
                        head_next = head_inc;
                        cnt_next  = cnt_reg - 1'b1;
                        lvl_we    = 1'b1;
                        lvl_wdata = {head_inc, cnt_next};
                    end
                    else
                    begin
                        st_we    = 1'b1;
                        st_wdata = {st_rdata[63:32], top_left};
                    end
                    state_next = (rem_next == '0) ? S_FIN : S_CHK;
                end
            end
            S_FIN:
            begin
                if (room)
                begin
                    emit        = 1'b1;
                    res_in.kind = cap_reg ? KIND_CAPPED : KIND_NO_FILL;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Two-entry result queue, so the walk keeps going while a result waits.
    assign empty = (oc_reg == 2'd0);
    assign res   = oq_reg[or_reg];

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq_reg[ow_reg] <= res_in;
        end
        c_reg    <= c_next;
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        n_reg    <= n_next;
        cap_reg  <= cap_next;
        head_reg <= head_next;
        cnt_reg  <= cnt_next;
        sa_reg   <= sa_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            la_reg    <= '0;
            ow_reg    <= 1'b0;
            or_reg    <= 1'b0;
            oc_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            la_reg    <= la_next;
            ow_reg    <= ow_reg ^ emit;
            or_reg    <= or_reg ^ (pop && !empty);
            oc_reg    <= oc_reg + 2'(emit) - 2'(pop && !empty);
        end
    end

endmodule

[design/limit_order_book_matcher_unit.sv]
// Top level of the limit order book matcher with price-time priority.
//
//  Channel  | Handshake               | Beat
//  ---------+-------------------------+--------------------------------------------
//  command  | push / full             | command, side, limit_price, order_quantity,
//           |                         | order_id
//  result   | empty / pop             | result_kind, buyer_id, seller_id, trade_price,
//           |                         | trade_quantity, remaining_quantity, last_of_run
//
// An add passes through the back end as a level read, then the update and its beat.
// A match reads and checks each price level visited and checks and applies each fill,
// paced by the registered reads of the level table and the order store; a final beat
// closes the run. After reset the level table is cleared one row a cycle, all
// 2 * 2^ceil(log2(levels)) rows (512 at the default size), before any command leaves
// the queue. The back end stalls only while two result beats wait to be popped.
module limit_order_book_matcher_unit import lobm_pkg::*; #(
    parameter int PRICE_TICKS = 256,
    parameter int LEVEL_DEPTH = 16,
    parameter int MAX_FILLS   = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic               side,
    input  logic [PRICE_W-1:0] limit_price,
    input  logic [QTY_W-1:0]   order_quantity,
    input  logic [ID_W-1:0]    order_id,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         result_kind,
    output logic [ID_W-1:0]    buyer_id,
    output logic [ID_W-1:0]    seller_id,
    output logic [PRICE_W-1:0] trade_price,
    output logic [QTY_W-1:0]   trade_quantity,
    output logic [QTY_W-1:0]   remaining_quantity,
    output logic               last_of_run
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;
    res_t res;

    // The front classifies each beat and holds it until the back end is free.
    lobm_front #(.PRICE_TICKS(PRICE_TICKS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .side           (side),
        .limit_price    (limit_price),
        .order_quantity (order_quantity),
        .order_id       (order_id),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    // The back end owns both books and produces every result beat.
    lobm_back #(
        .PRICE_TICKS (PRICE_TICKS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .MAX_FILLS   (MAX_FILLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .res       (res),
        .pop       (pop)
    );

    assign result_kind        = res.kind;
    assign buyer_id           = res.buyer;
    assign seller_id          = res.seller;
    assign trade_price        = res.price;
    assign trade_quantity     = res.qty;
    assign remaining_quantity = res.rem;
    assign last_of_run        = res.last;

endmodule
